// ===== rtl/core/apsc_pkg.sv =====
package apsc_pkg;

	// noise threshold register
	localparam int THRESH_W = 13;
	localparam logic [THRESH_W-1:0] THRESH_RESET = 13'd1050;

	// step count
	localparam int STEP_W = 16;

	// queue between front and back
	localparam int QDEPTH = 2;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	typedef enum logic [1:0] {
		F_IDLE,
		F_MUL,
		F_PUSH
	} front_state_t;

	typedef enum logic [2:0] {
		B_IDLE,
		B_SQRT,
		B_ACC,
		B_DIV,
		B_PEAK,
		B_EMIT
	} back_state_t;

endpackage

// ===== rtl/core/apsc_front.sv =====
module apsc_front import apsc_pkg::*; #(
	parameter int SAMPLE_BITS = 13,
	parameter int BLOCK_LEN   = 4
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic signed [SAMPLE_BITS-1:0] accel_x,
	input  logic signed [SAMPLE_BITS-1:0] accel_y,
	input  logic signed [SAMPLE_BITS-1:0] accel_z,
	input  q_stat_t                      qstat,
	output logic                         push,
	output logic [2*SAMPLE_BITS:0]       push_data
);

	localparam int SQ_W = 2 * SAMPLE_BITS;
	localparam int PH_W = (BLOCK_LEN > 2) ? $clog2(BLOCK_LEN) : 1;

	front_state_t state_q, state_d;

	logic [SAMPLE_BITS-1:0] x_q, y_q, z_q;
	logic [1:0]             axis_q;
	logic [SQ_W-1:0]        acc_q;
	logic [PH_W-1:0]        phase_q;

	logic                   accept;
	logic [SAMPLE_BITS-1:0] op;
	logic [SAMPLE_BITS-1:0] op_abs;
	logic [SQ_W-1:0]        sq;
	logic                   last;

	assign accept = in_valid && !in_stall;
	assign last   = (phase_q == PH_W'(BLOCK_LEN - 1));

	always_comb begin
		case (axis_q)
			2'd0:    op = x_q;
			2'd1:    op = y_q;
			default: op = z_q;
		endcase
	end

	// most negative value maps onto its unsigned magnitude
	assign op_abs = op[SAMPLE_BITS-1] ? (~op + 1'b1) : op;
	assign sq     = SQ_W'(op_abs) * SQ_W'(op_abs);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		in_stall  = 1'b1;
		push      = 1'b0;
		push_data = {last, acc_q};
		case (state_q)
			F_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					state_d = F_MUL;
				end
			end
			F_MUL: begin
				if (axis_q == 2'd2) begin
					state_d = F_PUSH;
				end
			end
			F_PUSH: begin
				if (!qstat.full) begin
					push    = 1'b1;
					state_d = F_IDLE;
				end
			end
			default: begin
				state_d = F_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= '0;
		end else if (push) begin
			phase_q <= last ? '0 : phase_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			x_q    <= accel_x;
			y_q    <= accel_y;
			z_q    <= accel_z;
			axis_q <= 2'd0;
			acc_q  <= '0;
		end else if (state_q == F_MUL) begin
			axis_q <= axis_q + 1'b1;
			acc_q  <= acc_q + sq;
		end
	end

endmodule

// ===== rtl/core/apsc_queue.sv =====
module apsc_queue import apsc_pkg::*; #(
	parameter int W = 27
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] push_data,
	input  logic         pop,
	output logic [W-1:0] pop_data,
	output q_stat_t      qstat
);

	localparam int PTR_W = $clog2(QDEPTH);
	localparam int CNT_W = $clog2(QDEPTH + 1);

	logic [W-1:0]     mem_q [QDEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign qstat.full  = (count_q == CNT_W'(QDEPTH));
	assign qstat.empty = (count_q == '0);
	assign pop_data    = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && qstat.full))
		else $error("push into full queue");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(pop && qstat.empty))
		else $error("pop from empty queue");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(QDEPTH))
		else $error("queue count out of range");

endmodule

// ===== rtl/core/apsc_back.sv =====
module apsc_back import apsc_pkg::*; #(
	parameter int SAMPLE_BITS = 13,
	parameter int BLOCK_LEN   = 4,
	parameter int PEAK_REACH  = 2
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  q_stat_t                qstat,
	input  logic [2*SAMPLE_BITS:0] q_data,
	output logic                   pop,
	input  logic [THRESH_W-1:0]    thresh,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic [STEP_W-1:0]      step_total,
	output logic                   step_detected
);

	localparam int SB     = SAMPLE_BITS;
	localparam int SQ_W   = 2 * SB;
	localparam int SUM_W  = SB + $clog2(BLOCK_LEN);
	localparam int CNT_W  = $clog2(SB);
	localparam int HD     = 2 * PEAK_REACH + 1;
	localparam int CMP_W  = (SB > THRESH_W) ? SB : THRESH_W;
	localparam int DIV_L  = $clog2(BLOCK_LEN);
	localparam int RSH    = SUM_W + DIV_L;
	localparam int RCP_W  = SUM_W + 1;
	localparam int PROD_W = SUM_W + RCP_W;
	// rounded-up reciprocal of the block length, exact for every block sum
	localparam logic [RCP_W-1:0] RECIP = RCP_W'(((64'd1 << RSH) + 64'(BLOCK_LEN) - 64'd1)
		/ 64'(BLOCK_LEN));

	back_state_t state_q, state_d;

	logic [SQ_W-1:0]   rad_q;
	logic [SB:0]       rem_q;
	logic [SB-1:0]     root_q;
	logic [CNT_W-1:0]  it_q;
	logic              last_q;
	logic [SUM_W-1:0]  sum_q;
	logic [SUM_W-1:0]  div_q;
	logic [SB-1:0]     hist_q [HD];
	logic [STEP_W-1:0] count_q;
	logic              det_q;
	logic              out_valid_q;

	logic [SB+2:0]     shifted, trial, diff;
	logic              sq_ge;
	logic [PROD_W-1:0] avg_prod;
	logic [SB-1:0]     avg;
	logic              sqrt_done;
	logic              is_peak, hit;
	logic              load_out;

	// one root digit per cycle from the top bit pair
	assign shifted = {rem_q, rad_q[SQ_W-1 -: 2]};
	assign trial   = {1'b0, root_q, 2'b01};
	assign diff    = shifted - trial;
	assign sq_ge   = (shifted >= trial);

	// block average by multiplying with the reciprocal of the block length
	assign avg_prod = PROD_W'(div_q) * PROD_W'(RECIP);
	assign avg      = avg_prod[RSH +: SB];

	assign sqrt_done = (it_q == CNT_W'(SB - 1));

	always_comb begin
		is_peak = 1'b1;
		for (int i = 0; i < HD; i++) begin
			if (i != PEAK_REACH && !(hist_q[PEAK_REACH] > hist_q[i])) begin
				is_peak = 1'b0;
			end
		end
	end

	assign hit = is_peak && (CMP_W'(hist_q[PEAK_REACH]) > CMP_W'(thresh));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		pop      = 1'b0;
		load_out = 1'b0;
		case (state_q)
			B_IDLE: begin
				if (!qstat.empty) begin
					pop     = 1'b1;
					state_d = B_SQRT;
				end
			end
			B_SQRT: begin
				if (sqrt_done) begin
					state_d = B_ACC;
				end
			end
			B_ACC: begin
				state_d = last_q ? B_DIV : B_EMIT;
			end
			B_DIV: begin
				state_d = B_PEAK;
			end
			B_PEAK: begin
				state_d = B_EMIT;
			end
			B_EMIT: begin
				if (!out_valid_q || !out_stall) begin
					load_out = 1'b1;
					state_d  = B_IDLE;
				end
			end
			default: begin
				state_d = B_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q       <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < HD; i++) begin
				hist_q[i] <= '0;
			end
		end else begin
			if (state_q == B_ACC) begin
				sum_q <= last_q ? '0 : sum_q + SUM_W'(root_q);
			end
			if (state_q == B_DIV) begin
				hist_q[0] <= avg;
				for (int i = 1; i < HD; i++) begin
					hist_q[i] <= hist_q[i-1];
				end
			end
			if (state_q == B_PEAK && hit) begin
				count_q <= count_q + 1'b1;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			B_IDLE: begin
				rad_q  <= q_data[SQ_W-1:0];
				last_q <= q_data[SQ_W];
				rem_q  <= '0;
				root_q <= '0;
				it_q   <= '0;
			end
			B_SQRT: begin
				rad_q  <= {rad_q[SQ_W-3:0], 2'b00};
				rem_q  <= sq_ge ? diff[SB:0] : shifted[SB:0];
				root_q <= {root_q[SB-2:0], sq_ge};
				it_q   <= it_q + 1'b1;
			end
			B_ACC: begin
				div_q <= sum_q + SUM_W'(root_q);
				det_q <= 1'b0;
			end
			B_PEAK: begin
				det_q <= hit;
			end
			default: begin
			end
		endcase
		if (load_out) begin
			step_total    <= count_q;
			step_detected <= det_q;
		end
	end

	assign out_valid = out_valid_q;

	a_div_only_on_block_end: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == B_DIV) |-> last_q)
		else $error("average taken on a sample that does not close a block");

	a_count_moves_on_peak: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q != $past(count_q)) |-> ($past(state_q) == B_PEAK && $past(hit)))
		else $error("step count changed outside a confirmed peak");

	a_load_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		load_out |-> (!out_valid_q || !out_stall))
		else $error("output register overwritten while held");

endmodule

// ===== rtl/core/accel_peak_step_counter.sv =====
// Step counter for a signed three-axis accelerometer. Each input beat is one
// sample (accel_x, accel_y, accel_z, two's complement) and yields exactly one
// output beat carrying the wrapping 16-bit step_total and a step_detected flag.
// The magnitude is the floor square root of x*x+y*y+z*z; magnitudes are
// averaged over non-overlapping blocks of BLOCK_LEN samples, and an average is
// a step when it is strictly above all PEAK_REACH averages on each side and
// strictly above noise_threshold, so a step is flagged PEAK_REACH blocks late.
// The front takes in a sample and squares the three axes on one shared
// multiplier, one axis at a time, taking no new sample until the sum is
// pushed; a two-entry queue feeds the back. The back is bound by its
// iterative square root, with two extra states on each sample that closes
// a block for the average (a constant reciprocal multiply) and the peak
// test. The output register lets the back finish the next sample while a
// result beat waits on out_stall.
// noise_threshold is written through cfg_valid/cfg_data (always ready) and
// resets to 1050; write it only while the block is idle.
module accel_peak_step_counter import apsc_pkg::*; #(
	parameter int BLOCK_LEN   = 4,
	parameter int PEAK_REACH  = 2,
	parameter int SAMPLE_BITS = 13
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// sample channel
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic signed [SAMPLE_BITS-1:0] accel_x,
	input  logic signed [SAMPLE_BITS-1:0] accel_y,
	input  logic signed [SAMPLE_BITS-1:0] accel_z,
	// result channel
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [STEP_W-1:0]             step_total,
	output logic                          step_detected,
	// threshold write channel
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [THRESH_W-1:0]           cfg_data
);

	localparam int QW = 2 * SAMPLE_BITS + 1;

	logic [THRESH_W-1:0] thresh_q;
	q_stat_t             qstat;
	logic                push, pop;
	logic [QW-1:0]       push_data, pop_data;

	// threshold register, a write beat is taken every cycle
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thresh_q <= THRESH_RESET;
		end else if (cfg_valid && cfg_ready) begin
			thresh_q <= cfg_data;
		end
	end

	// front: accept sample, sum of squares, block position flag
	apsc_front #(
		.SAMPLE_BITS (SAMPLE_BITS),
		.BLOCK_LEN   (BLOCK_LEN)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.accel_x   (accel_x),
		.accel_y   (accel_y),
		.accel_z   (accel_z),
		.qstat     (qstat),
		.push      (push),
		.push_data (push_data)
	);

	// decoupling queue
	apsc_queue #(
		.W (QW)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.pop_data  (pop_data),
		.qstat     (qstat)
	);

	// back: square root, block average, peak test, result register
	apsc_back #(
		.SAMPLE_BITS (SAMPLE_BITS),
		.BLOCK_LEN   (BLOCK_LEN),
		.PEAK_REACH  (PEAK_REACH)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.qstat         (qstat),
		.q_data        (pop_data),
		.pop           (pop),
		.thresh        (thresh_q),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.step_total    (step_total),
		.step_detected (step_detected)
	);

endmodule

// ===== tb/accel_peak_step_counter_tb.sv =====
module accel_peak_step_counter_tb;
	import apsc_pkg::*;

	localparam int SAMPLE_BITS = 13;
	localparam int BLOCK_LEN   = 4;
	localparam int PEAK_REACH  = 2;
	localparam int HIST_DEPTH  = 2 * PEAK_REACH + 1;
	// watchdog limit for about 1600 beats in all
	localparam int CYCLE_LIMIT = 1000000;
	localparam int HOLDOFF_LEN = 400;
	localparam int SETTLE_CYCLES = 60;

	typedef logic signed [SAMPLE_BITS-1:0] axis_t;

	typedef struct {
		axis_t x;
		axis_t y;
		axis_t z;
	} accel_sample_t;

	typedef struct {
		logic [STEP_W-1:0] total;
		logic              detected;
	} step_report_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                in_valid = 1'b0;
	logic                in_stall;
	axis_t               accel_x = '0;
	axis_t               accel_y = '0;
	axis_t               accel_z = '0;
	logic                out_valid;
	logic                out_stall = 1'b0;
	logic [STEP_W-1:0]   step_total;
	logic                step_detected;
	logic                cfg_valid = 1'b0;
	logic                cfg_ready;
	logic [THRESH_W-1:0] cfg_data = '0;

	accel_peak_step_counter #(
		.BLOCK_LEN  (BLOCK_LEN),
		.PEAK_REACH (PEAK_REACH),
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.accel_x      (accel_x),
		.accel_y      (accel_y),
		.accel_z      (accel_z),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.step_total   (step_total),
		.step_detected(step_detected),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data)
	);

	always #5 clk = ~clk;

	// samples waiting for the driver, and step reports waiting for the monitor
	accel_sample_t pending_samples[$];
	step_report_t  expected_reports[$];

	// shadow copy of the counter state
	logic [THRESH_W-1:0] noise_thr = THRESH_RESET;
	logic [14:0]         mag_acc = '0;
	int unsigned         blk_fill = 0;
	logic [12:0]         avg_hist[HIST_DEPTH] = '{default: '0};
	logic [STEP_W-1:0]   step_cnt = '0;

	// idle and stall rates in percent, set per phase
	int unsigned send_idle_pct = 0;
	int unsigned stall_pct = 0;
	bit          holdoff_req = 1'b0;

	int unsigned error_count = 0;
	int unsigned cycle_count = 0;

	task automatic flag_error(input string msg);
		error_count++;
		if (error_count <= 10) begin
			$display("%s", msg);
		end
	endtask

	// floor square root, one result digit per pass
	function automatic logic [12:0] floor_sqrt(input logic [31:0] n);
		logic [31:0] rem;
		logic [31:0] root;
		logic [31:0] probe;
		rem = n;
		root = '0;
		probe = 32'h4000_0000;
		while (probe > rem) begin
			probe >>= 2;
		end
		while (probe != 0) begin
			if (rem >= root + probe) begin
				rem -= root + probe;
				root = (root >> 1) + probe;
			end else begin
				root >>= 1;
			end
			probe >>= 2;
		end
		return root[12:0];
	endfunction

	// advance the shadow state by one accepted sample and queue its report
	task automatic track_sample(input axis_t x, input axis_t y, input axis_t z);
		int          sx;
		int          sy;
		int          sz;
		logic [31:0] energy;
		logic [12:0] mid;
		bit          peak;
		step_report_t rep;
		sx = x;
		sy = y;
		sz = z;
		energy = sx * sx + sy * sy + sz * sz;
		mag_acc = mag_acc + 15'(floor_sqrt(energy));
		blk_fill++;
		rep.detected = 1'b0;
		if (blk_fill == BLOCK_LEN) begin
			for (int i = HIST_DEPTH - 1; i > 0; i--) begin
				avg_hist[i] = avg_hist[i-1];
			end
			avg_hist[0] = 13'(mag_acc / BLOCK_LEN);
			mid = avg_hist[PEAK_REACH];
			peak = 1'b1;
			// any tie with a neighbour kills the peak
			for (int i = 0; i < HIST_DEPTH; i++) begin
				if (i != PEAK_REACH && !(mid > avg_hist[i])) begin
					peak = 1'b0;
				end
			end
			if (peak && mid > noise_thr) begin
				rep.detected = 1'b1;
				step_cnt++;
			end
			mag_acc = '0;
			blk_fill = 0;
		end
		rep.total = step_cnt;
		expected_reports.push_back(rep);
	endtask

	// driver: a beat moves when in_valid is high and in_stall low
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			accel_x <= '0;
			accel_y <= '0;
			accel_z <= '0;
		end else begin : drive_blk
			logic          fire;
			accel_sample_t s;
			fire = in_valid && !in_stall;
			if (fire) begin
				track_sample(accel_x, accel_y, accel_z);
			end
			// payload holds while stalled
			if (!in_valid || fire) begin
				if (pending_samples.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
					s = pending_samples.pop_front();
					in_valid <= 1'b1;
					accel_x <= s.x;
					accel_y <= s.y;
					accel_z <= s.z;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// receiver stall: random per phase, plus one long hold-off on request
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin : stall_blk
			static int unsigned hold_left = 0;
			static bit          holdoff_taken = 1'b0;
			if (holdoff_req && !holdoff_taken) begin
				holdoff_taken = 1'b1;
				hold_left = HOLDOFF_LEN;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= ($urandom_range(0, 99) < stall_pct);
			end
		end
	end

	// monitor: compare every result beat with the oldest expected report
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin : check_blk
			step_report_t want;
			if (expected_reports.size() == 0) begin
				flag_error($sformatf("unexpected result beat: step_total=%0d step_detected=%0b",
					step_total, step_detected));
			end else begin
				want = expected_reports.pop_front();
				if (step_total !== want.total) begin
					flag_error($sformatf("step_total: expected %0d, got %0d",
						want.total, step_total));
				end
				if (step_detected !== want.detected) begin
					flag_error($sformatf("step_detected: expected %0b, got %0b (step_total %0d)",
						want.detected, step_detected, want.total));
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// wait until every sample is sent and every report has come back
	task automatic wait_quiet();
		@(negedge clk);
		while (pending_samples.size() > 0 || in_valid || expected_reports.size() > 0) begin
			@(negedge clk);
		end
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_threshold(input logic [THRESH_W-1:0] value);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		noise_thr = value;
		@(negedge clk);
	endtask

	task automatic push_sample(input int x, input int y, input int z);
		accel_sample_t s;
		s.x = axis_t'(x);
		s.y = axis_t'(y);
		s.z = axis_t'(z);
		pending_samples.push_back(s);
	endtask

	// random block levels: mostly clean blocks of four along one
	// dominant axis, some exact repeats for ties, the rest raw noise beats;
	// drain_every > 0 makes the sender pause until all reports are in
	task automatic feed_random(input int unsigned count, input int unsigned drain_every);
		int unsigned   sent;
		int unsigned   since_drain;
		int            level;
		int            sgn;
		int            kind;
		accel_sample_t last_blk[BLOCK_LEN];
		accel_sample_t s;
		sent = 0;
		since_drain = 0;
		for (int i = 0; i < BLOCK_LEN; i++) begin
			last_blk[i] = '{x: '0, y: '0, z: '0};
		end
		while (sent < count) begin
			kind = $urandom_range(0, 99);
			if (kind < 15) begin
				// noise beat, any value of every field
				push_sample($urandom_range(0, 8191), $urandom_range(0, 8191),
					$urandom_range(0, 8191));
				sent++;
				since_drain++;
			end else if (kind < 25) begin
				// same block again, equal average
				for (int i = 0; i < BLOCK_LEN; i++) begin
					pending_samples.push_back(last_blk[i]);
				end
				sent += BLOCK_LEN;
				since_drain += BLOCK_LEN;
			end else begin
				level = $urandom_range(0, 4000);
				for (int i = 0; i < BLOCK_LEN; i++) begin
					sgn = $urandom_range(0, 1) ? -1 : 1;
					s.x = axis_t'(sgn * (level + $urandom_range(0, 95)));
					s.y = axis_t'($urandom_range(0, 600) - 300);
					s.z = axis_t'($urandom_range(0, 600) - 300);
					// rotate the dominant axis now and then
					if ($urandom_range(0, 3) == 0) begin
						s = '{x: s.z, y: s.x, z: s.y};
					end
					last_blk[i] = s;
					pending_samples.push_back(s);
				end
				sent += BLOCK_LEN;
				since_drain += BLOCK_LEN;
			end
			if (drain_every > 0 && since_drain >= drain_every) begin
				wait_quiet();
				since_drain = 0;
			end
		end
		wait_quiet();
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: a large first average against the zero-filled history
		for (int i = 0; i < BLOCK_LEN; i++) push_sample(4095, 4095, 4095);
		push_sample(-1, 1, 0);
		push_sample(1, -1, -1);
		push_sample(0, 0, 0);
		push_sample(-1, -1, 1);
		for (int i = 0; i < BLOCK_LEN; i++) push_sample(0, 0, 0);
		// two identical blocks at full negative scale: a tie, no peak
		for (int i = 0; i < 2 * BLOCK_LEN; i++) push_sample(-4096, -4096, -4096);
		push_sample(4095, -4096, 0);
		push_sample(0, 4095, -4096);
		push_sample(-4096, 0, 4095);
		push_sample(1000, -2000, 3000);
		wait_quiet();

		// no idling; the receiver holds off long enough to back up the input
		holdoff_req = 1'b1;
		feed_random(400, 0);

		// lowest threshold, sender mostly idle and pausing for drains
		write_threshold('0);
		send_idle_pct = 69;
		feed_random(400, 100);

		// highest threshold, no average can pass; receiver mostly stalled
		write_threshold({THRESH_W{1'b1}});
		send_idle_pct = 0;
		stall_pct = 69;
		feed_random(400, 0);

		// a threshold in the middle of the level range, both sides idling
		write_threshold(THRESH_W'($urandom_range(1200, 3000)));
		send_idle_pct = 35;
		stall_pct = 35;
		feed_random(400, 0);

		if (expected_reports.size() > 0) begin
			flag_error($sformatf("%0d step reports never arrived", expected_reports.size()));
		end
		if (error_count == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
